[rtl/core/hslc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared widths, constants and stage records of the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslc_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int FIX_W      = FRAC_BITS + 1;
  localparam int REG_W      = 9;
  localparam int HUE_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int WGT_W      = 6;
  localparam int NUM_W      = FIX_W + WGT_W;
  localparam int DIV_SHIFT  = FRAC_BITS + 8;
  localparam int DIV_K      = (1 << DIV_SHIFT) / 60;
  localparam int DIV_K_W    = DIV_SHIFT - 5;
  localparam int PIPE_DEPTH = 6;
  localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

  localparam logic [FIX_W-1:0]     FX_ONE     = FIX_W'(1 << FRAC_BITS);
  localparam logic [REG_W-1:0]     REG_ONE    = REG_W'(256);
  localparam logic [REG_W-1:0]     SAT_RESET  = REG_W'(205);
  localparam logic [REG_W-1:0]     LIGHT_RESET = REG_W'(154);
  localparam logic [HUE_W-1:0]     HUE_WRAP   = HUE_W'(360);
  localparam logic [NUM_W-1:0]     SECTOR_DEG = NUM_W'(60);
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

  typedef struct packed {
    sector_t            sector;
    logic [WGT_W-1:0]   weight;
    logic [FIX_W-1:0]   one_minus_dist;
    logic [FIX_W-1:0]   sat;
    logic [FIX_W-1:0]   light;
    logic [BYTE_W-1:0]  alpha;
  } front_t;

  typedef struct packed {
    sector_t            sector;
    logic [FIX_W-1:0]   quot;
    logic [NUM_W-1:0]   num;
    logic [FIX_W-1:0]   chroma;
    logic [FIX_W-1:0]   offset;
    logic [BYTE_W-1:0]  alpha;
  } arith_t;

  function automatic logic [FIX_W-1:0] to_fixed(input logic [REG_W-1:0] v);
    logic [REG_W-1:0]           clamped;
    logic [REG_W+FRAC_BITS-1:0] wide;
    clamped = (v > REG_ONE) ? REG_ONE : v;
    wide    = {clamped, {FRAC_BITS{1'b0}}} >> 8;
    return wide[FIX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/hslc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hslc_front
// Input stage: reduce hue, find sector and weight, convert registers to fixed.
// ----------------------------------------------------------------------------
module hslc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hslc_pkg::HUE_W-1:0]   hue_degrees,
  input  wire logic [hslc_pkg::BYTE_W-1:0]  alpha_in,
  input  wire logic [hslc_pkg::REG_W-1:0]   saturation,
  input  wire logic [hslc_pkg::REG_W-1:0]   lightness,
  output logic                              st_valid,
  input  wire logic                         st_ready,
  output hslc_pkg::front_t                  st
);

  logic [hslc_pkg::HUE_W-1:0]   hue;
  logic [hslc_pkg::HUE_W-1:0]   wdiff;
  logic [hslc_pkg::FIX_W-1:0]   l_fix;
  logic [hslc_pkg::FIX_W:0]     two_l;
  logic [hslc_pkg::FIX_W:0]     spread;
  hslc_pkg::sector_t            sector;
  hslc_pkg::front_t             st_next;

  always_comb begin
    hue = (hue_degrees >= hslc_pkg::HUE_WRAP) ? hue_degrees - hslc_pkg::HUE_WRAP
                                              : hue_degrees;
    priority if (hue < 9'd60) begin
      sector = hslc_pkg::SEC_RED_YELLOW;
      wdiff  = hue;
    end else if (hue < 9'd120) begin
      sector = hslc_pkg::SEC_YELLOW_GREEN;
      wdiff  = 9'd120 - hue;
    end else if (hue < 9'd180) begin
      sector = hslc_pkg::SEC_GREEN_CYAN;
      wdiff  = hue - 9'd120;
    end else if (hue < 9'd240) begin
      sector = hslc_pkg::SEC_CYAN_BLUE;
      wdiff  = 9'd240 - hue;
    end else if (hue < 9'd300) begin
      sector = hslc_pkg::SEC_BLUE_MAGENTA;
      wdiff  = hue - 9'd240;
    end else begin
      sector = hslc_pkg::SEC_MAGENTA_RED;
      wdiff  = 9'd360 - hue;
    end

    l_fix  = hslc_pkg::to_fixed(lightness);
    two_l  = {l_fix, 1'b0};
    spread = (two_l >= {1'b0, hslc_pkg::FX_ONE}) ? two_l - {1'b0, hslc_pkg::FX_ONE}
                                                 : {1'b0, hslc_pkg::FX_ONE} - two_l;

    st_next.sector         = sector;
    st_next.weight         = wdiff[hslc_pkg::WGT_W-1:0];
    st_next.one_minus_dist = hslc_pkg::FX_ONE - spread[hslc_pkg::FIX_W-1:0];
    st_next.sat            = hslc_pkg::to_fixed(saturation);
    st_next.light          = l_fix;
    st_next.alpha          = alpha_in;
  end

  assign in_ready = !st_valid || st_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hslc_arith.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hslc_arith
// Three stages: chroma, secondary numerator and offset, reciprocal quotient.
// ----------------------------------------------------------------------------
module hslc_arith (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hslc_pkg::front_t in_st,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hslc_pkg::arith_t      out_st
);

  localparam logic [hslc_pkg::DIV_K_W-1:0] DivK = hslc_pkg::DIV_K_W'(hslc_pkg::DIV_K);

  // stage 1: chroma
  logic                              v1;
  logic                              rdy1;
  hslc_pkg::sector_t                 sec1;
  logic [hslc_pkg::WGT_W-1:0]        wgt1;
  logic [hslc_pkg::FIX_W-1:0]        chroma1;
  logic [hslc_pkg::FIX_W-1:0]        light1;
  logic [hslc_pkg::BYTE_W-1:0]       alpha1;
  logic [2*hslc_pkg::FIX_W-1:0]      chroma_prod;

  // stage 2: numerator and offset
  logic                              v2;
  logic                              rdy2;
  hslc_pkg::sector_t                 sec2;
  logic [hslc_pkg::NUM_W-1:0]        num2;
  logic [hslc_pkg::FIX_W-1:0]        chroma2;
  logic [hslc_pkg::FIX_W-1:0]        offset2;
  logic [hslc_pkg::BYTE_W-1:0]       alpha2;

  // stage 3: quotient estimate
  logic                              rdy3;
  logic [hslc_pkg::NUM_W+hslc_pkg::DIV_K_W-1:0] quot_prod;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign chroma_prod = {{hslc_pkg::FIX_W{1'b0}}, in_st.one_minus_dist}
                     * {{hslc_pkg::FIX_W{1'b0}}, in_st.sat};
  assign quot_prod   = {{hslc_pkg::DIV_K_W{1'b0}}, num2} * {{hslc_pkg::NUM_W{1'b0}}, DivK};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      sec1    <= in_st.sector;
      wgt1    <= in_st.weight;
      chroma1 <= chroma_prod[hslc_pkg::FRAC_BITS +: hslc_pkg::FIX_W];
      light1  <= in_st.light;
      alpha1  <= in_st.alpha;
    end
    if (v1 && rdy2) begin
      sec2    <= sec1;
      num2    <= hslc_pkg::NUM_W'(chroma1) * hslc_pkg::NUM_W'(wgt1);
      chroma2 <= chroma1;
      offset2 <= light1 - (chroma1 >> 1);
      alpha2  <= alpha1;
    end
    if (v2 && rdy3) begin
      out_st.sector <= sec2;
      out_st.quot   <= quot_prod[hslc_pkg::DIV_SHIFT +: hslc_pkg::FIX_W];
      out_st.num    <= num2;
      out_st.chroma <= chroma2;
      out_st.offset <= offset2;
      out_st.alpha  <= alpha2;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hslc_mix.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hslc_mix
// Correct the quotient, order channels by sector, add offset, scale to bytes.
// ----------------------------------------------------------------------------
module hslc_mix (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire hslc_pkg::arith_t            in_st,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hslc_pkg::BYTE_W-1:0]      red,
  output logic [hslc_pkg::BYTE_W-1:0]      green,
  output logic [hslc_pkg::BYTE_W-1:0]      blue,
  output logic [hslc_pkg::BYTE_W-1:0]      alpha_out
);

  localparam int SUM_W  = hslc_pkg::FIX_W + 1;
  localparam int BPROD_W = hslc_pkg::FIX_W + 8;

  logic                            v1;
  logic                            rdy1;
  logic                            rdy2;
  logic [hslc_pkg::NUM_W-1:0]      q_times;
  logic [hslc_pkg::NUM_W-1:0]      rem;
  logic [hslc_pkg::FIX_W-1:0]      xval;
  logic [hslc_pkg::FIX_W-1:0]      cval;
  logic [hslc_pkg::FIX_W-1:0]      r_sel;
  logic [hslc_pkg::FIX_W-1:0]      g_sel;
  logic [hslc_pkg::FIX_W-1:0]      b_sel;
  logic [SUM_W-1:0]                r_sum;
  logic [SUM_W-1:0]                g_sum;
  logic [SUM_W-1:0]                b_sum;
  logic [hslc_pkg::FIX_W-1:0]      r_val;
  logic [hslc_pkg::FIX_W-1:0]      g_val;
  logic [hslc_pkg::FIX_W-1:0]      b_val;
  logic [hslc_pkg::BYTE_W-1:0]     alpha1;
  logic [BPROD_W-1:0]              r_scaled;
  logic [BPROD_W-1:0]              g_scaled;
  logic [BPROD_W-1:0]              b_scaled;

  function automatic logic [hslc_pkg::FIX_W-1:0] clamp_one(input logic [SUM_W-1:0] v);
    return (v > {1'b0, hslc_pkg::FX_ONE}) ? hslc_pkg::FX_ONE : v[hslc_pkg::FIX_W-1:0];
  endfunction

  always_comb begin
    q_times = ({{(hslc_pkg::NUM_W-hslc_pkg::FIX_W){1'b0}}, in_st.quot} << 6)
            - ({{(hslc_pkg::NUM_W-hslc_pkg::FIX_W){1'b0}}, in_st.quot} << 2);
    rem     = in_st.num - q_times;
    xval    = (rem >= hslc_pkg::SECTOR_DEG) ? in_st.quot + 1'b1 : in_st.quot;
    cval    = in_st.chroma;

    unique case (in_st.sector)
      hslc_pkg::SEC_RED_YELLOW:   begin r_sel = cval; g_sel = xval; b_sel = '0;   end
      hslc_pkg::SEC_YELLOW_GREEN: begin r_sel = xval; g_sel = cval; b_sel = '0;   end
      hslc_pkg::SEC_GREEN_CYAN:   begin r_sel = '0;   g_sel = cval; b_sel = xval; end
      hslc_pkg::SEC_CYAN_BLUE:    begin r_sel = '0;   g_sel = xval; b_sel = cval; end
      hslc_pkg::SEC_BLUE_MAGENTA: begin r_sel = xval; g_sel = '0;   b_sel = cval; end
      hslc_pkg::SEC_MAGENTA_RED:  begin r_sel = cval; g_sel = '0;   b_sel = xval; end
      default:                    begin r_sel = '0;   g_sel = '0;   b_sel = '0;   end
    endcase

    r_sum = {1'b0, r_sel} + {1'b0, in_st.offset};
    g_sum = {1'b0, g_sel} + {1'b0, in_st.offset};
    b_sum = {1'b0, b_sel} + {1'b0, in_st.offset};

    r_scaled = {r_val, 8'b0} - {8'b0, r_val};
    g_scaled = {g_val, 8'b0} - {8'b0, g_val};
    b_scaled = {b_val, 8'b0} - {8'b0, b_val};
  end

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      r_val  <= clamp_one(r_sum);
      g_val  <= clamp_one(g_sum);
      b_val  <= clamp_one(b_sum);
      alpha1 <= in_st.alpha;
    end
    if (v1 && rdy2) begin
      red       <= r_scaled[hslc_pkg::FRAC_BITS +: hslc_pkg::BYTE_W];
      green     <= g_scaled[hslc_pkg::FRAC_BITS +: hslc_pkg::BYTE_W];
      blue      <= b_scaled[hslc_pkg::FRAC_BITS +: hslc_pkg::BYTE_W];
      alpha_out <= alpha1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hsl_to_rgb_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Hue stream to RGB bytes using saturation and lightness registers.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    hue_degrees[8:0], alpha_in[7:0]
//  out      out_valid / out_ready  red, green, blue, alpha_out [7:0]
//  cfg      cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[8:0]
//
//  Six register stages: front, chroma multiply, numerator multiply, reciprocal
//  multiply for the divide by 60, channel mix, byte scaling.
//  One transaction per cycle sustained while out_ready stays high.
//  Each stage holds on a stall and fills any bubble ahead of it.
//  Reset empties the pipeline and loads saturation 205 and lightness 154.
//  cfg_ready is always high; unknown register indexes are dropped.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [hslc_pkg::HUE_W-1:0]       hue_degrees,
  input  wire logic [hslc_pkg::BYTE_W-1:0]      alpha_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [hslc_pkg::BYTE_W-1:0]           red,
  output logic [hslc_pkg::BYTE_W-1:0]           green,
  output logic [hslc_pkg::BYTE_W-1:0]           blue,
  output logic [hslc_pkg::BYTE_W-1:0]           alpha_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hslc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hslc_pkg::REG_W-1:0]       cfg_data
);

  logic [hslc_pkg::REG_W-1:0] saturation;
  logic [hslc_pkg::REG_W-1:0] lightness;
  logic                       fr_valid;
  logic                       fr_ready;
  hslc_pkg::front_t           fr_st;
  logic                       ar_valid;
  logic                       ar_ready;
  hslc_pkg::arith_t           ar_st;
  logic [hslc_pkg::OCC_W-1:0] occupancy;
  logic                       in_fire;
  logic                       out_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= hslc_pkg::SAT_RESET;
      lightness  <= hslc_pkg::LIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hslc_pkg::REG_SATURATION) begin
        saturation <= cfg_data;
      end
      if (cfg_index == hslc_pkg::REG_LIGHTNESS) begin
        lightness <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (in_fire && !out_fire) begin
      occupancy <= occupancy + 1'b1;
    end else if (!in_fire && out_fire) begin
      occupancy <= occupancy - 1'b1;
    end
  end

  hslc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .hue_degrees (hue_degrees),
    .alpha_in    (alpha_in),
    .saturation  (saturation),
    .lightness   (lightness),
    .st_valid    (fr_valid),
    .st_ready    (fr_ready),
    .st          (fr_st)
  );

  hslc_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_st     (fr_st),
    .out_valid (ar_valid),
    .out_ready (ar_ready),
    .out_st    (ar_st)
  );

  hslc_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ar_valid),
    .in_ready  (ar_ready),
    .in_st     (ar_st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha_out (alpha_out)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= hslc_pkg::OCC_W'(hslc_pkg::PIPE_DEPTH))
    else $error("pipeline holds more transactions than stages");

  a_empty_no_out: assert property (@(posedge clk) disable iff (rst)
    (occupancy == '0) |-> !out_valid)
    else $error("result presented with no transaction in flight");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && occupancy == hslc_pkg::OCC_W'(hslc_pkg::PIPE_DEPTH)))
    else $error("input stalled while pipeline not full and blocked");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !out_fire) |=> (occupancy == $past(occupancy) + 1'b1))
    else $error("accepted transaction not counted");

endmodule
`default_nettype wire
